@@ sv/swhs_pkg.sv @@
package swhs_pkg;

   localparam int MAX_TRANSITIONS = 85;
   localparam int DATA_BITS       = 40;
   localparam int NUM_BYTES       = DATA_BITS / 8;
   localparam int BIT_COUNT_W     = $clog2(DATA_BITS + 1);
   localparam int TRANS_W         = 7;
   localparam int TICK_W          = 16;

   localparam logic [7:0]  RST_BIT_THRESHOLD = 8'd16;
   localparam logic [7:0]  RST_EDGE_TIMEOUT  = 8'd255;
   localparam logic [15:0] RST_START_LOW     = 16'd18000;
   localparam logic [9:0]  RST_START_HIGH    = 10'd40;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOW,
      PH_HIGH,
      PH_RECV
   } phase_type;

   typedef enum logic [1:0] {
      CSR_BIT_THRESHOLD,
      CSR_EDGE_TIMEOUT,
      CSR_START_LOW,
      CSR_START_HIGH
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  bit_threshold;
      logic [7:0]  edge_timeout;
      logic [15:0] start_low_ticks;
      logic [9:0]  start_high_ticks;
   } cfg_type;

   typedef logic [NUM_BYTES-1:0][7:0] frame_bytes_type;

   typedef struct packed {
      logic            drive_enable;
      logic            drive_level;
      logic            busy_res;
      logic            done_res;
      logic            frame_ok;
      frame_bytes_type bytes;
   } rsp_type;

endpackage

@@ sv/swhs_unpack.sv @@
module swhs_unpack (
   input  logic [swhs_pkg::DATA_BITS-1:0]   data_shift,
   input  logic [swhs_pkg::BIT_COUNT_W-1:0] bit_count,
   output swhs_pkg::frame_bytes_type        bytes,
   output logic                             sum_match
);

   logic [7:0] sum;

   // bytes fill from the msb side; a partial byte sits right-aligned
   always_comb begin
      logic [swhs_pkg::BIT_COUNT_W-1:0] lo;
      logic [swhs_pkg::BIT_COUNT_W-1:0] sh;
      logic [swhs_pkg::DATA_BITS-1:0]   tmp;
      logic [7:0]                       mask;
      lo   = '0;
      sh   = '0;
      tmp  = '0;
      mask = '0;
      for (int k = 0; k < swhs_pkg::NUM_BYTES; k++) begin
         lo = swhs_pkg::BIT_COUNT_W'(8 * k);
         if (bit_count <= lo) begin
            bytes[k] = '0;
         end else if (bit_count >= lo + swhs_pkg::BIT_COUNT_W'(8)) begin
            sh       = bit_count - lo - swhs_pkg::BIT_COUNT_W'(8);
            tmp      = data_shift >> sh;
            bytes[k] = tmp[7:0];
         end else begin
            sh       = bit_count - lo;
            mask     = 8'((9'd1 << sh) - 9'd1);
            bytes[k] = data_shift[7:0] & mask;
         end
      end
   end

   assign sum       = bytes[0] + bytes[1] + bytes[2] + bytes[3];
   assign sum_match = (sum == bytes[4]);

endmodule

@@ sv/swhs_core.sv @@
module swhs_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              req_type,
   input  logic              pin_level,
   input  swhs_pkg::cfg_type cfg,
   output swhs_pkg::rsp_type res
);

   swhs_pkg::phase_type                   phase_ff, phase_in;
   logic [swhs_pkg::TICK_W-1:0]          tick_count_ff, tick_count_in;
   logic                                 last_level_ff, last_level_in;
   logic [swhs_pkg::TRANS_W-1:0]         trans_index_ff, trans_index_in;
   logic [swhs_pkg::BIT_COUNT_W-1:0]     bit_count_ff, bit_count_in;
   logic [swhs_pkg::DATA_BITS-1:0]       data_shift_ff, data_shift_in;

   logic                      drv_en;
   logic                      drv_lvl;
   logic                      finish;
   logic                      sum_match;
   swhs_pkg::frame_bytes_type bytes;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= swhs_pkg::PH_IDLE;
         tick_count_ff  <= '0;
         last_level_ff  <= 1'b1;
         trans_index_ff <= '0;
         bit_count_ff   <= '0;
         data_shift_ff  <= '0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         tick_count_ff  <= tick_count_in;
         last_level_ff  <= last_level_in;
         trans_index_ff <= trans_index_in;
         bit_count_ff   <= bit_count_in;
         data_shift_ff  <= data_shift_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      tick_count_in  = tick_count_ff;
      last_level_in  = last_level_ff;
      trans_index_in = trans_index_ff;
      bit_count_in   = bit_count_ff;
      data_shift_in  = data_shift_ff;
      drv_en         = 1'b0;
      drv_lvl        = 1'b0;
      finish         = 1'b0;

      if (req_type) begin
         data_shift_in  = '0;
         bit_count_in   = '0;
         trans_index_in = '0;
         tick_count_in  = '0;
         last_level_in  = 1'b1;
         phase_in       = swhs_pkg::PH_LOW;
      end else begin
         unique case (phase_ff) inside
            swhs_pkg::PH_LOW, swhs_pkg::PH_HIGH: begin
               drv_en        = 1'b1;
               drv_lvl       = (phase_ff == swhs_pkg::PH_HIGH);
               tick_count_in = tick_count_ff + swhs_pkg::TICK_W'(1);
            end
            swhs_pkg::PH_RECV: begin
               if (pin_level == last_level_ff) begin
                  tick_count_in = tick_count_ff + swhs_pkg::TICK_W'(1);
               end else begin
                  // even-numbered edges from the fourth on close a data bit
                  if (trans_index_ff >= swhs_pkg::TRANS_W'(4) && !trans_index_ff[0] &&
                      bit_count_ff < swhs_pkg::BIT_COUNT_W'(swhs_pkg::DATA_BITS)) begin
                     data_shift_in = {data_shift_ff[swhs_pkg::DATA_BITS-2:0],
                                      (tick_count_ff > {8'd0, cfg.bit_threshold})};
                     bit_count_in  = bit_count_ff + swhs_pkg::BIT_COUNT_W'(1);
                  end
                  last_level_in  = pin_level;
                  tick_count_in  = swhs_pkg::TICK_W'(1);
                  trans_index_in = trans_index_ff + swhs_pkg::TRANS_W'(1);
                  if (trans_index_in >= swhs_pkg::TRANS_W'(swhs_pkg::MAX_TRANSITIONS)) begin
                     finish = 1'b1;
                  end
               end
               if (tick_count_in >= {8'd0, cfg.edge_timeout}) begin
                  finish = 1'b1;
               end
               if (finish) begin
                  phase_in = swhs_pkg::PH_IDLE;
               end
            end
            default: ;
         endcase
      end

      // zero-length start phases fall straight through
      if (phase_in == swhs_pkg::PH_LOW && tick_count_in >= cfg.start_low_ticks) begin
         phase_in      = swhs_pkg::PH_HIGH;
         tick_count_in = '0;
      end
      if (phase_in == swhs_pkg::PH_HIGH &&
          tick_count_in >= {6'd0, cfg.start_high_ticks}) begin
         phase_in       = swhs_pkg::PH_RECV;
         tick_count_in  = '0;
         last_level_in  = 1'b1;
         trans_index_in = '0;
      end

      // a request drives per the phase it leads to
      if (req_type) begin
         drv_en  = (phase_in == swhs_pkg::PH_LOW) || (phase_in == swhs_pkg::PH_HIGH);
         drv_lvl = (phase_in == swhs_pkg::PH_HIGH);
      end
   end

   swhs_unpack u_unpack (
      .data_shift (data_shift_in),
      .bit_count  (bit_count_in),
      .bytes      (bytes),
      .sum_match  (sum_match)
   );

   always_comb begin
      res.drive_enable = drv_en;
      res.drive_level  = drv_lvl;
      res.busy_res     = (phase_in != swhs_pkg::PH_IDLE);
      res.done_res     = finish;
      res.frame_ok     = finish && sum_match &&
                         (bit_count_in >= swhs_pkg::BIT_COUNT_W'(swhs_pkg::DATA_BITS));
      res.bytes        = bytes;
   end

   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      res.frame_ok |-> res.done_res)
      else $error("frame_ok without done");

   a_done_from_recv: assert property (@(posedge clock) disable iff (reset)
      step_en && res.done_res |-> phase_ff == swhs_pkg::PH_RECV && !req_type)
      else $error("frame finished outside receive phase");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      res.done_res |-> !res.busy_res)
      else $error("busy after frame finished");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= swhs_pkg::BIT_COUNT_W'(swhs_pkg::DATA_BITS))
      else $error("bit count beyond frame length");

   a_req_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && req_type |=> bit_count_ff == '0 && data_shift_ff == '0)
      else $error("request did not clear received data");

endmodule

@@ sv/single_wire_humidity_sensor_reader.sv @@
// channel   | ports                                   | direction
// req       | req_valid/ready, req_type, req_pin_level | in, one transaction per tick or request
// rsp       | rsp_valid/ready, rsp_* result fields     | out, one transaction per req transaction
// csr       | csr_valid/ready, csr_index, csr_wdata    | in, register writes
// a req transaction lands in the input register; when the output register is free or draining,
// a step does the state update and captures the result for rsp; one per cycle sustained while rsp_ready holds.
// the output register stall backs up into the input register and then to req_ready.
// synchronous reset clears control state and loads register defaults; csr is always ready.
module single_wire_humidity_sensor_reader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic        req_pin_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_drive_enable,
   output logic        rsp_drive_level,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_frame_ok,
   output logic [7:0]  rsp_humidity_int,
   output logic [7:0]  rsp_humidity_frac,
   output logic [7:0]  rsp_temp_int,
   output logic [7:0]  rsp_temp_frac,
   output logic [7:0]  rsp_check_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   swhs_pkg::cfg_type cfg_ff;
   logic              in_valid_ff;
   logic              in_req_ff;
   logic              in_pin_ff;
   logic              rsp_valid_ff;
   swhs_pkg::rsp_type rsp_ff;
   swhs_pkg::rsp_type core_res;
   logic              step_en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_threshold    <= swhs_pkg::RST_BIT_THRESHOLD;
         cfg_ff.edge_timeout     <= swhs_pkg::RST_EDGE_TIMEOUT;
         cfg_ff.start_low_ticks  <= swhs_pkg::RST_START_LOW;
         cfg_ff.start_high_ticks <= swhs_pkg::RST_START_HIGH;
      end else if (csr_valid) begin
         unique case (csr_index)
            swhs_pkg::CSR_BIT_THRESHOLD: cfg_ff.bit_threshold    <= csr_wdata[7:0];
            swhs_pkg::CSR_EDGE_TIMEOUT:  cfg_ff.edge_timeout     <= csr_wdata[7:0];
            swhs_pkg::CSR_START_LOW:     cfg_ff.start_low_ticks  <= csr_wdata;
            swhs_pkg::CSR_START_HIGH:    cfg_ff.start_high_ticks <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // stage 2 loads when the input register holds a request and the output register is free or draining
   assign step_en   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_req_ff <= req_type;
         in_pin_ff <= req_pin_level;
      end
   end

   swhs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .req_type  (in_req_ff),
      .pin_level (in_pin_ff),
      .cfg       (cfg_ff),
      .res       (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= core_res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_enable  = rsp_ff.drive_enable;
   assign rsp_drive_level   = rsp_ff.drive_level;
   assign rsp_busy_res      = rsp_ff.busy_res;
   assign rsp_done_res      = rsp_ff.done_res;
   assign rsp_frame_ok      = rsp_ff.frame_ok;
   assign rsp_humidity_int  = rsp_ff.bytes[0];
   assign rsp_humidity_frac = rsp_ff.bytes[1];
   assign rsp_temp_int      = rsp_ff.bytes[2];
   assign rsp_temp_frac     = rsp_ff.bytes[3];
   assign rsp_check_byte    = rsp_ff.bytes[4];

endmodule
